// File: rtl/sst_pkg.sv
// sst_pkg: shared types and codes for the sorted score table
// no dependencies
`timescale 1ns / 1ps

package sst_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_RANK   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADRANK = 2'd3;

  typedef struct packed {
    logic [23:0] id;
    logic [15:0] score;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic load_rd;
    logic shift_rd;
  } cell_ctrl_t;

endpackage

// File: rtl/sst_cell.sv
// sst_cell: one slot of the sorted chain, with its own readout register
// depends on sst_pkg
`timescale 1ns / 1ps

module sst_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 8
) (
  input  logic               clk,
  input  sst_pkg::cell_ctrl_t ctrl,
  input  sst_pkg::entry_t    new_entry,
  input  logic [CNT_W-1:0]   count,
  input  sst_pkg::entry_t    prev_entry,
  input  logic               prev_gt,
  input  sst_pkg::entry_t    next_rd,
  output logic               gt,
  output sst_pkg::entry_t    entry,
  output sst_pkg::entry_t    rd
);
  import sst_pkg::*;

  logic occupied;

  assign occupied = CNT_W'(IDX) < count;
  assign gt       = occupied && (entry.score > new_entry.score);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (prev_gt) begin
        entry <= prev_entry;
      end else if (gt || (count == CNT_W'(IDX))) begin
        entry <= new_entry;
      end
    end
    if (ctrl.load_rd) begin
      rd <= entry;
    end else if (ctrl.shift_rd) begin
      rd <= next_rd;
    end
  end

endmodule

// File: rtl/sst_div.sv
// sst_div: restoring divider, one quotient bit per cycle
// depends on nothing beyond its parameters
`timescale 1ns / 1ps

module sst_div #(
  parameter int TOT_W = 24,
  parameter int CNT_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TOT_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [TOT_W-1:0] quot,
  output logic [CNT_W-1:0] rem
);
  localparam int STEP_W = $clog2(TOT_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign diff = {rem, quot[TOT_W-1]};
  assign fits = diff >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(TOT_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= CNT_W'(diff - {1'b0, dvs});
      end else begin
        rem <= diff[CNT_W-1:0];
      end
      quot <= {quot[TOT_W-2:0], fits};
    end
  end

endmodule

// File: rtl/sorted_score_table.sv
// sorted_score_table: an accepted insert writes the cell chain registers directly; a rank query then
// shifts the readout chain rank-1 places; every item then runs the divider over a quotient of
// max(23, 16 + clog2(TABLE_DEPTH+1)) bits, 24 at the default depth.
// an item passes from accept through S_SHIFT (query only), S_DIVGO, S_DIV and S_DONE; one item at a time,
// so a new item is accepted only after S_DONE has presented the last result to the output.
// reset (synchronous, rst high) empties the table and clears the total; stored slots keep junk.
`timescale 1ns / 1ps

module sorted_score_table #(
  parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // entry_id, entry_score, rank_wanted
  input  logic [1:0]  s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,  // entry_count, score_total, score_average, found_id,
                                // found_score, zero pad
  output logic [1:0]  m_tuser   // status
);
  import sst_pkg::*;

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int TOT_W  = (16 + CNT_W > 23) ? 16 + CNT_W : 23;
  localparam int CMP_W  = CNT_W + 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_DIVGO = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [TOT_W-1:0] total;
  logic [1:0]       status;
  entry_t           found;
  logic [IDX_W-1:0] shift_cnt;

  logic [1:0]       action;
  entry_t           new_entry;
  logic [7:0]       rank;
  logic             accept;
  logic             full;
  logic             bad_rank;
  cell_ctrl_t       ctrl;

  entry_t           entries [TABLE_DEPTH];
  entry_t           rds     [TABLE_DEPTH];
  logic             gts     [TABLE_DEPTH];

  logic             div_start;
  logic             div_done;
  logic [TOT_W-1:0] quot;
  logic [CNT_W-1:0] rem;
  logic             round_up;
  logic [TOT_W-1:0] avg;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] rank_ext;
  logic             out_free;

  assign action          = s_tuser;
  assign new_entry.id    = s_tdata[23:0];
  assign new_entry.score = s_tdata[39:24];
  assign rank            = s_tdata[47:40];

  assign s_tready  = state == S_IDLE;
  assign accept    = s_tvalid && s_tready;
  assign full      = count == CNT_W'(TABLE_DEPTH);
  assign count_ext = CMP_W'(count);
  assign rank_ext  = CMP_W'(rank);
  assign bad_rank  = (rank == 8'd0) || (rank_ext > count_ext)
                     || (rank_ext > CMP_W'(TABLE_DEPTH));
  assign out_free  = !m_tvalid || m_tready;

  assign ctrl.ins      = accept && (action == ACT_INSERT) && !full;
  assign ctrl.load_rd  = accept && (action == ACT_RANK) && (count != '0) && !bad_rank;
  assign ctrl.shift_rd = (state == S_SHIFT) && (shift_cnt != '0);

  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_t prev_e;
      logic   prev_g;
      entry_t next_r;
      if (i == 0) begin : g_first
        assign prev_e = '0;
        assign prev_g = 1'b0;
      end else begin : g_mid
        assign prev_e = entries[i-1];
        assign prev_g = gts[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
        assign next_r = '0;
      end else begin : g_next
        assign next_r = rds[i+1];
      end
      sst_cell #(
        .IDX   (i),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .count      (count),
        .prev_entry (prev_e),
        .prev_gt    (prev_g),
        .next_rd    (next_r),
        .gt         (gts[i]),
        .entry      (entries[i]),
        .rd         (rds[i])
      );
    end
  endgenerate

  assign div_start = state == S_DIVGO;

  sst_div #(
    .TOT_W (TOT_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total),
    .divisor  (count),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign round_up = {rem, 1'b0} >= {1'b0, count};
  assign avg      = (count == '0) ? '0 : quot + TOT_W'(round_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= ctrl.load_rd ? S_SHIFT : S_DIVGO;
            unique case (action)
              ACT_INSERT: begin
                if (!full) begin
                  count <= count + CNT_W'(1);
                  total <= total + TOT_W'(new_entry.score);
                end
              end
              ACT_CLEAR: begin
                count <= '0;
                total <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (shift_cnt == '0) begin
            state <= S_DIVGO;
          end
        end
        S_DIVGO: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found     <= '0;
      shift_cnt <= IDX_W'(rank - 8'd1);
      priority if (action == ACT_INSERT && full) begin
        status <= ST_FULL;
      end else if (action == ACT_RANK && count == '0) begin
        status <= ST_EMPTY;
      end else if (action == ACT_RANK && bad_rank) begin
        status <= ST_BADRANK;
      end else begin
        status <= ST_OK;
      end
    end else if (state == S_SHIFT) begin
      if (shift_cnt == '0) begin
        found <= rds[0];
      end else begin
        shift_cnt <= shift_cnt - IDX_W'(1);
      end
    end
    if (state == S_DONE && out_free) begin
      m_tuser <= status;
      m_tdata <= {1'b0, found.score, found.id, avg[15:0], total[22:0], count_ext[7:0]};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_CLEAR) |=> (count == '0 && total == '0))
    else $error("clear did not empty the table");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_INSERT && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the table");

  a_result_issued: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (m_tvalid && state == S_IDLE))
    else $error("finished item not presented");

endmodule
